// ----- design/rrts_pkg.sv -----
// shared types and constants for the round-robin thread scheduler
// no dependencies

package rrts_pkg;

  localparam int unsigned NumThreads = 16;
  localparam int unsigned TidW = 4;
  localparam int unsigned QlenW = 5;

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_SPAWN = 3'd1,
    ACT_TERM  = 3'd2,
    ACT_BLOCK = 3'd3,
    ACT_RESUME = 3'd4,
    ACT_SLEEP = 3'd5,
    ACT_QUERY = 3'd6,
    ACT_NONE  = 3'd7
  } action_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_NO_SLOT  = 3'd2;
  localparam logic [2:0] ST_BLK_MAIN = 3'd3;
  localparam logic [2:0] ST_SLP_MAIN = 3'd4;
  localparam logic [2:0] ST_SHUTDOWN = 3'd5;

  // per-thread state held in one cell
  typedef struct packed {
    logic        active;
    logic        blocked;
    logic        asleep;
    logic [15:0] sleep_left;
    logic [31:0] run_count;
  } thr_t;

  // thread zero after reset: active with one quantum credited
  localparam thr_t ThrMainReset = '{
    active: 1'b1, blocked: 1'b0, asleep: 1'b0, sleep_left: 16'd0, run_count: 32'd1
  };

endpackage

// ----- design/rrts_cell.sv -----
// one thread cell of the rotating thread ring
// depends on rrts_pkg

module rrts_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  rrts_pkg::thr_t    reset_value,
  input  rrts_pkg::thr_t    din,
  output rrts_pkg::thr_t    dout
);

  rrts_pkg::thr_t entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= reset_value;
    end else if (shift) begin
      entry <= din;
    end
  end

  assign dout = entry;

endmodule

// ----- design/rrts_queue_cell.sv -----
// one slot of the ready queue compaction row
// depends on rrts_pkg

module rrts_queue_cell (
  input  logic                       clk,
  input  logic                       shift,
  input  logic [rrts_pkg::TidW-1:0]  din,
  output logic [rrts_pkg::TidW-1:0]  dout
);

  logic [rrts_pkg::TidW-1:0] slot;

  // queue payload needs no reset, queue_len says which slots are live
  always_ff @(posedge clk) begin
    if (shift) begin
      slot <= din;
    end
  end

  assign dout = slot;

endmodule

// ----- design/round_robin_thread_scheduler_top.sv -----
// top level of the round-robin thread scheduler
// depends on rrts_pkg, rrts_cell, rrts_queue_cell

// Round-robin thread scheduler for 16 threads. A command word (action,
// thread_id, sleep_quanta) is taken when start is high and busy is low; one
// result word comes back, marked by done for exactly one cycle, and the
// receiver cannot hold it off. Thread state lives in a ring of 16 cells that
// rotates one position per cycle during a walk; the ready queue is a row of
// 16 slots with the head in slot 0. Every command passes through a decode
// step, a full pass of the thread ring (updates the target thread and, in a
// switch, counts sleepers down and appends the ones that wake, in id order),
// a queue step (removes one entry or appends one) and a result step. A
// switch also has a dispatch step that pops the queue head and a second
// ring pass that credits the new running thread, before the result step.
// busy drops while done is high, so a new word can be taken at the edge
// that ends the done cycle.

module round_robin_thread_scheduler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [3:0]  thread_id,
  input  logic [15:0] sleep_quanta,
  output logic        done,
  output logic [2:0]  status,
  output logic [3:0]  new_tid,
  output logic [3:0]  running_tid,
  output logic [31:0] thread_quanta,
  output logic [31:0] total_quanta
);

  localparam int unsigned N = rrts_pkg::NumThreads;
  localparam int unsigned TW = rrts_pkg::TidW;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_TWALK  = 7'b0000100,
    S_QOP    = 7'b0001000,
    S_DISP   = 7'b0010000,
    S_CREDIT = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;

  // latched command
  rrts_pkg::action_t      act;
  logic [TW-1:0]          tid;
  logic [15:0]            sq;

  // walk counter, index of the entry at ring position 0
  // (back at zero whenever no walk is running)
  logic [TW-1:0]          cnt;

  // control state
  logic [TW-1:0]          cur;
  logic [31:0]            total;
  logic [rrts_pkg::QlenW-1:0] qlen;

  // per-command decisions
  logic                   do_sw;     // a switch follows
  logic                   do_q_remove;
  logic                   do_push_tid;
  logic                   do_reset;
  logic                   spawn_found;
  logic [TW-1:0]          spawn_id;
  logic [2:0]             st;
  logic [31:0]            tq;
  logic                   cur_requeue;

  // decode of the latched command
  rrts_pkg::action_t      dec_act;
  logic [2:0]             dec_st;
  logic                   dec_sw;
  logic                   dec_q_remove;
  logic                   dec_push_tid;
  logic                   dec_reset;
  logic                   dec_found;
  logic [TW-1:0]          dec_spawn_id;

  // thread ring
  rrts_pkg::thr_t ring [N];
  rrts_pkg::thr_t ring_in [N];
  rrts_pkg::thr_t ring_rst [N];
  logic           ring_shift;
  rrts_pkg::thr_t head;      // entry at position 0 (thread cnt)
  rrts_pkg::thr_t head_upd;  // head after the command's own update
  rrts_pkg::thr_t head_new;  // head after the sleeper countdown
  logic           head_wake;
  logic           wake_app;

  // queue row
  logic [TW-1:0]  qr [N];
  logic [TW-1:0]  qr_in [N];
  logic [N-1:0]   q_shift;
  logic [N-1:0]   q_match;
  logic           q_hit;
  logic           q_app_en;
  logic [TW-1:0]  q_app_val;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_thr
      assign ring_rst[g] = (g == 0) ? rrts_pkg::ThrMainReset : '0;
      rrts_cell u_cell (
        .clk         (clk),
        .rst         (rst || (state == S_DONE && do_reset)),
        .shift       (ring_shift),
        .reset_value (ring_rst[g]),
        .din         (ring_in[g]),
        .dout        (ring[g])
      );
      assign ring_in[g] = (g == N-1) ? head_new : ring[(g+1) % N];

      rrts_queue_cell u_q (
        .clk   (clk),
        .shift (q_shift[g]),
        .din   (qr_in[g]),
        .dout  (qr[g])
      );
    end
  endgenerate

  assign head = ring[0];
  assign ring_shift = (state == S_TWALK) || (state == S_CREDIT);

  // thread ring step: update entry cnt as it passes position 0
  always_comb begin
    head_upd = head;
    head_new = head;
    head_wake = 1'b0;
    if (state == S_TWALK) begin
      unique case (act)
        rrts_pkg::ACT_TERM: begin
          if (cnt == tid) begin
            head_upd.active = 1'b0;
            head_upd.blocked = 1'b0;
            head_upd.asleep = 1'b0;
            head_upd.sleep_left = '0;
          end
        end
        rrts_pkg::ACT_BLOCK: begin
          if (cnt == tid) head_upd.blocked = 1'b1;
        end
        rrts_pkg::ACT_SLEEP: begin
          if (cnt == cur) begin
            head_upd.asleep = 1'b1;
            head_upd.sleep_left = sq;
          end
        end
        rrts_pkg::ACT_SPAWN: begin
          if (spawn_found && cnt == spawn_id) begin
            head_upd = '0;
            head_upd.active = 1'b1;
          end
        end
        rrts_pkg::ACT_RESUME: begin
          if (cnt == tid) head_upd.blocked = 1'b0;
        end
        default: begin
        end
      endcase
      head_new = head_upd;
      // sleeper countdown in a switch
      if (do_sw && head_upd.active && head_upd.asleep) begin
        if (head_upd.sleep_left <= 16'd1) begin
          head_new.sleep_left = '0;
          head_new.asleep = 1'b0;
          head_wake = 1'b1;
        end else begin
          head_new.sleep_left = head_upd.sleep_left - 16'd1;
        end
      end
    end else if (state == S_CREDIT) begin
      if (cnt == cur) begin
        head_new.run_count = head.run_count + 32'd1;
      end
    end
  end

  // a waking sleeper joins the queue at once, the runner only at requeue time
  assign wake_app = head_wake && !head_upd.blocked && (cnt != cur);

  // queue row: appends land in slot qlen, a removal pulls every slot from
  // the first match on one place toward the head, dispatch pops slot 0
  always_comb begin
    q_app_en = 1'b0;
    q_app_val = tid;
    if (state == S_TWALK) begin
      q_app_en = wake_app;
      q_app_val = cnt;
    end else if (state == S_QOP && !do_q_remove) begin
      if (do_sw) begin
        q_app_en = cur_requeue;
        q_app_val = cur;
      end else if (act == rrts_pkg::ACT_SPAWN && spawn_found) begin
        q_app_en = 1'b1;
        q_app_val = spawn_id;
      end else if (do_push_tid) begin
        q_app_en = 1'b1;
        q_app_val = tid;
      end
    end
    q_hit = 1'b0;
    q_shift = '0;
    for (int i = 0; i < N; i++) begin
      q_match[i] = (qr[i] == tid) && (rrts_pkg::QlenW'(i) < qlen);
      q_hit = q_hit || q_match[i];
      qr_in[i] = qr[(i + 1) % N];
      if (state == S_QOP && do_q_remove && q_hit) q_shift[i] = 1'b1;
      if (state == S_DISP) q_shift[i] = 1'b1;
      if (q_app_en && qlen[TW-1:0] == TW'(i)) begin
        q_shift[i] = 1'b1;
        qr_in[i] = q_app_val;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_DECODE;
      S_DECODE: state_next = S_TWALK;
      S_TWALK:  if (cnt == TW'(N-1)) state_next = S_QOP;
      S_QOP:    state_next = do_sw ? S_DISP : S_DONE;
      S_DISP:   state_next = S_CREDIT;
      S_CREDIT: if (cnt == TW'(N-1)) state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // ring sits at rest during decode, so cell i holds thread i
  logic valid_id;
  logic [N-1:0] act_m, blk_m, slp_m;
  always_comb begin
    for (int i = 0; i < N; i++) begin
      act_m[i] = ring[i].active;
      blk_m[i] = ring[i].blocked;
      slp_m[i] = ring[i].asleep;
    end
  end
  assign valid_id = act_m[tid];

  // command decode
  always_comb begin
    dec_act = act;
    dec_st = rrts_pkg::ST_OK;
    dec_sw = 1'b0;
    dec_q_remove = 1'b0;
    dec_push_tid = 1'b0;
    dec_reset = 1'b0;
    dec_found = 1'b0;
    dec_spawn_id = '0;
    // lowest free slot
    for (int i = N-1; i >= 0; i--) begin
      if (!act_m[i]) begin
        dec_found = 1'b1;
        dec_spawn_id = TW'(i);
      end
    end
    unique case (act)
      rrts_pkg::ACT_TICK: dec_sw = 1'b1;
      rrts_pkg::ACT_SPAWN: begin
        if (!dec_found) dec_st = rrts_pkg::ST_NO_SLOT;
      end
      rrts_pkg::ACT_TERM: begin
        if (!valid_id) begin
          dec_st = rrts_pkg::ST_INVALID;
          dec_act = rrts_pkg::ACT_NONE;
        end else if (tid == '0) begin
          dec_st = rrts_pkg::ST_SHUTDOWN;
          dec_reset = 1'b1;
          dec_act = rrts_pkg::ACT_NONE;
        end else begin
          dec_q_remove = !blk_m[tid] && !slp_m[tid] && tid != cur;
          dec_sw = (tid == cur);
        end
      end
      rrts_pkg::ACT_BLOCK: begin
        if (!valid_id) begin
          dec_st = rrts_pkg::ST_INVALID;
          dec_act = rrts_pkg::ACT_NONE;
        end else if (tid == '0) begin
          dec_st = rrts_pkg::ST_BLK_MAIN;
          dec_act = rrts_pkg::ACT_NONE;
        end else if (blk_m[tid]) begin
          dec_act = rrts_pkg::ACT_NONE;
        end else begin
          dec_sw = (tid == cur);
          dec_q_remove = (tid != cur) && !slp_m[tid];
        end
      end
      rrts_pkg::ACT_RESUME: begin
        if (!valid_id) begin
          dec_st = rrts_pkg::ST_INVALID;
          dec_act = rrts_pkg::ACT_NONE;
        end else if (!blk_m[tid] && !slp_m[tid]) begin
          dec_act = rrts_pkg::ACT_NONE;
        end else begin
          dec_push_tid = !slp_m[tid];
        end
      end
      rrts_pkg::ACT_SLEEP: begin
        if (cur == '0) begin
          dec_st = rrts_pkg::ST_SLP_MAIN;
          dec_act = rrts_pkg::ACT_NONE;
        end else begin
          dec_sw = 1'b1;
        end
      end
      rrts_pkg::ACT_QUERY: begin
        if (!valid_id) dec_st = rrts_pkg::ST_INVALID;
        dec_act = rrts_pkg::ACT_NONE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      cur   <= '0;
      total <= 32'd1;
      qlen  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_DONE);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act <= rrts_pkg::action_t'(action);
            tid <= thread_id;
            sq  <= sleep_quanta;
          end
        end
        S_DECODE: begin
          act <= dec_act;
          st <= dec_st;
          do_sw <= dec_sw;
          do_q_remove <= dec_q_remove;
          do_push_tid <= dec_push_tid;
          do_reset <= dec_reset;
          spawn_found <= dec_found;
          spawn_id <= dec_spawn_id;
          tq <= (act == rrts_pkg::ACT_QUERY && valid_id) ? ring[tid].run_count : '0;
        end
        S_TWALK: begin
          cnt <= cnt + 1'b1;
          if (wake_app) qlen <= qlen + 1'b1;
          if (cnt == cur) begin
            cur_requeue <= head_new.active && !head_new.blocked && !head_new.asleep;
          end
        end
        S_QOP: begin
          if (do_q_remove) begin
            qlen <= qlen - rrts_pkg::QlenW'(q_hit);
          end else if (q_app_en) begin
            qlen <= qlen + 1'b1;
          end
        end
        S_DISP: begin
          total <= total + 32'd1;
          // empty queue falls back to thread zero
          if (qlen != '0) begin
            cur <= qr[0];
            qlen <= qlen - 1'b1;
          end else begin
            cur <= '0;
          end
        end
        S_CREDIT: cnt <= cnt + 1'b1;
        S_DONE: begin
          status <= st;
          new_tid <= (act == rrts_pkg::ACT_SPAWN && spawn_found) ? spawn_id : '0;
          thread_quanta <= tq;
          if (do_reset) begin
            cur <= '0;
            total <= 32'd1;
            qlen <= '0;
            running_tid <= '0;
            total_quanta <= 32'd1;
          end else begin
            running_tid <= cur;
            total_quanta <= total;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE) || rst;

`ifndef SYNTHESIS
  a_done_from_walk: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DONE)) else $error("done without result cycle");
  a_busy_on_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
  a_qlen_bound: assert property (@(posedge clk) disable iff (rst)
    qlen <= rrts_pkg::QlenW'(N)) else $error("queue overflow");
`endif

endmodule
